@@ rtl/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and constants of the property-list text lexer: item formats,
// token kind codes and the packet that carries the results of one text byte.
// ----------------------------------------------------------------------------
package plt_pkg;

  // Most results that a single text byte can produce.
  localparam int MAX_RESULTS = 6;
  localparam int IDX_W       = $clog2(MAX_RESULTS);
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  // Default number of packets held between the front and the back.
  localparam int DEF_QUEUE_DEPTH = 4;

  // Token kinds.
  localparam logic [4:0] KIND_LBRACK       = 5'd0;
  localparam logic [4:0] KIND_RBRACK       = 5'd1;
  localparam logic [4:0] KIND_LPAREN       = 5'd2;
  localparam logic [4:0] KIND_RPAREN       = 5'd3;
  localparam logic [4:0] KIND_COLON        = 5'd4;
  localparam logic [4:0] KIND_COMMA        = 5'd5;
  localparam logic [4:0] KIND_INT          = 5'd6;
  localparam logic [4:0] KIND_FLOAT        = 5'd7;
  localparam logic [4:0] KIND_STRING       = 5'd8;
  localparam logic [4:0] KIND_SYMBOL       = 5'd9;
  localparam logic [4:0] KIND_IDENT        = 5'd10;
  localparam logic [4:0] KIND_PLUS         = 5'd11;
  localparam logic [4:0] KIND_MINUS        = 5'd12;
  localparam logic [4:0] KIND_TIMES        = 5'd13;
  localparam logic [4:0] KIND_DIVIDE       = 5'd14;
  localparam logic [4:0] KIND_MOD          = 5'd15;
  localparam logic [4:0] KIND_NOT          = 5'd16;
  localparam logic [4:0] KIND_AND          = 5'd17;
  localparam logic [4:0] KIND_OR           = 5'd18;
  localparam logic [4:0] KIND_EQUAL        = 5'd19;
  localparam logic [4:0] KIND_INEQUAL      = 5'd20;
  localparam logic [4:0] KIND_GREATER      = 5'd21;
  localparam logic [4:0] KIND_GREATER_EQ   = 5'd22;
  localparam logic [4:0] KIND_SMALLER      = 5'd23;
  localparam logic [4:0] KIND_SMALLER_EQ   = 5'd24;
  localparam logic [4:0] KIND_CONCAT       = 5'd25;
  localparam logic [4:0] KIND_SPACE_CONCAT = 5'd26;
  localparam logic [4:0] KIND_VOID         = 5'd27;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } text_item_t;

  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_begin;
    logic       token_end;
    logic       failed;
    logic       last_of_run;
  } token_item_t;

  // One result without its run mark; the back end adds that mark.
  typedef struct packed {
    logic [4:0] token_kind;
    logic [7:0] value_byte;
    logic       has_byte;
    logic       token_begin;
    logic       token_end;
    logic       failed;
  } tok_t;

  // All results caused by one text byte.
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    tok_t [MAX_RESULTS-1:0]       toks;
  } packet_t;

endpackage

@@ rtl/plt_front.sv @@
// ----------------------------------------------------------------------------
// plt_front
// Lexer state machine. Takes one text byte per cycle unless the queue is full,
// classifies it by current mode and builds the full list of results it causes.
// ----------------------------------------------------------------------------
module plt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                text_valid,
  output logic                text_stall,
  input  plt_pkg::text_item_t text_item,
  output logic                push,
  output plt_pkg::packet_t    push_packet,
  input  logic                queue_full
);
  import plt_pkg::*;

  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_IDENT   = 4'd1;
  localparam logic [3:0] MODE_NUMBER  = 4'd2;
  localparam logic [3:0] MODE_SYMBOL  = 4'd3;
  localparam logic [3:0] MODE_STRING  = 4'd4;
  localparam logic [3:0] MODE_KEYWORD = 4'd5;
  localparam logic [3:0] MODE_GT      = 4'd6;
  localparam logic [3:0] MODE_LT      = 4'd7;
  localparam logic [3:0] MODE_AMP     = 4'd8;

  localparam logic [2:0] KW_NOT  = 3'd0;
  localparam logic [2:0] KW_AND  = 3'd1;
  localparam logic [2:0] KW_OR   = 3'd2;
  localparam logic [2:0] KW_MOD  = 3'd3;
  localparam logic [2:0] KW_VOID = 3'd4;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_A_LOW  = 8'h61;
  localparam logic [7:0] CH_M_LOW  = 8'h6D;
  localparam logic [7:0] CH_N_LOW  = 8'h6E;
  localparam logic [7:0] CH_O_LOW  = 8'h6F;
  localparam logic [7:0] CH_V_LOW  = 8'h76;

  localparam int NUM_CAND = 10;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // Letter of a keyword at a position; byte 0 is the first letter.
  function automatic logic [7:0] kw_char(input logic [2:0] id, input logic [1:0] pos);
    logic [3:0][7:0] word;
    unique case (id)
      KW_AND:  word = 32'h00_64_6E_61;
      KW_OR:   word = 32'h00_00_72_6F;
      KW_MOD:  word = 32'h00_64_6F_6D;
      KW_VOID: word = 32'h64_69_6F_76;
      default: word = 32'h00_74_6F_6E;
    endcase
    return word[pos];
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] id);
    logic [2:0] len;
    unique case (id)
      KW_OR:   len = 3'd2;
      KW_VOID: len = 3'd4;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [2:0] id);
    logic [4:0] kind;
    unique case (id)
      KW_AND:  kind = KIND_AND;
      KW_OR:   kind = KIND_OR;
      KW_MOD:  kind = KIND_MOD;
      KW_VOID: kind = KIND_VOID;
      default: kind = KIND_NOT;
    endcase
    return kind;
  endfunction

  function automatic tok_t mk(input logic [4:0] kind, input logic [7:0] c,
                              input logic has, input logic beg, input logic fin,
                              input logic fail);
    tok_t t;
    t.token_kind  = kind;
    t.value_byte  = has ? c : 8'h00;
    t.has_byte    = has;
    t.token_begin = beg;
    t.token_end   = fin;
    t.failed      = fail;
    return t;
  endfunction

  // Lexer state.
  logic [3:0] lex_mode;
  logic       number_has_point;
  logic [7:0] keyword_pending [3];
  logic [2:0] keyword_id;
  logic [1:0] keyword_matched;
  logic       drop_rest;

  logic [3:0] lex_mode_next;
  logic       number_has_point_next;
  logic [2:0] keyword_id_next;
  logic [1:0] keyword_matched_next;
  logic       drop_rest_next;

  logic       accept;
  logic [7:0] b;
  logic       last;

  logic [2:0] kid_eff;
  logic [2:0] len_c;
  logic [4:0] kwk;
  logic       kw_cont;
  logic       kw_done;
  logic       kw_fail;
  logic [3:0] eff_mode;

  logic       fresh_v;
  tok_t       fresh_tok;
  logic [3:0] fresh_mode;
  logic       fresh_kw;
  logic [2:0] fresh_kid;

  logic       use_fresh;
  logic [3:0] mode1;
  logic       hp1;
  logic [1:0] km1;
  logic [2:0] kid1;
  logic       drop1;
  logic       pend_we;
  logic [1:0] pend_idx;
  logic [7:0] pend1 [3];
  logic [4:0] run_kind;
  logic [4:0] pair_kind;

  tok_t                    cand [NUM_CAND];
  logic [NUM_CAND-1:0]     cv;
  logic [COUNT_W-1:0]      cnt;
  tok_t [MAX_RESULTS-1:0]  res;

  assign b          = text_item.char_byte;
  assign last       = text_item.last_char;
  assign text_stall = queue_full;
  assign accept     = text_valid && !text_stall;

  // Classification of a byte that starts a new token.
  always_comb begin
    fresh_v    = 1'b1;
    fresh_tok  = mk(KIND_IDENT, b, 1'b1, 1'b1, 1'b0, 1'b0);
    fresh_mode = MODE_IDLE;
    fresh_kw   = 1'b0;
    fresh_kid  = KW_NOT;
    unique case (b)
      CH_SPACE, CH_CR, CH_LF, CH_TAB: fresh_v = 1'b0;
      CH_LBRACK: fresh_tok = mk(KIND_LBRACK, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_RBRACK: fresh_tok = mk(KIND_RBRACK, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_LPAREN: fresh_tok = mk(KIND_LPAREN, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_RPAREN: fresh_tok = mk(KIND_RPAREN, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_COLON:  fresh_tok = mk(KIND_COLON, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_COMMA:  fresh_tok = mk(KIND_COMMA, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_PLUS:   fresh_tok = mk(KIND_PLUS, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_MINUS:  fresh_tok = mk(KIND_MINUS, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_STAR:   fresh_tok = mk(KIND_TIMES, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_SLASH:  fresh_tok = mk(KIND_DIVIDE, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_EQUAL:  fresh_tok = mk(KIND_EQUAL, b, 1'b1, 1'b1, 1'b1, 1'b0);
      CH_GT: begin
        fresh_v    = 1'b0;
        fresh_mode = MODE_GT;
      end
      CH_LT: begin
        fresh_v    = 1'b0;
        fresh_mode = MODE_LT;
      end
      CH_AMP: begin
        fresh_v    = 1'b0;
        fresh_mode = MODE_AMP;
      end
      CH_HASH: begin
        fresh_tok  = mk(KIND_SYMBOL, b, 1'b0, 1'b1, 1'b0, 1'b0);
        fresh_mode = MODE_SYMBOL;
      end
      CH_QUOTE: begin
        fresh_tok  = mk(KIND_STRING, b, 1'b0, 1'b1, 1'b0, 1'b0);
        fresh_mode = MODE_STRING;
      end
      CH_N_LOW, CH_A_LOW, CH_O_LOW, CH_M_LOW, CH_V_LOW: begin
        fresh_v    = 1'b0;
        fresh_kw   = 1'b1;
        fresh_mode = MODE_KEYWORD;
        unique case (b)
          CH_A_LOW: fresh_kid = KW_AND;
          CH_O_LOW: fresh_kid = KW_OR;
          CH_M_LOW: fresh_kid = KW_MOD;
          CH_V_LOW: fresh_kid = KW_VOID;
          default:  fresh_kid = KW_NOT;
        endcase
      end
      default: begin
        if (is_digit(b)) begin
          fresh_tok  = mk(KIND_INT, b, 1'b1, 1'b1, 1'b0, 1'b0);
          fresh_mode = MODE_NUMBER;
        end else begin
          fresh_mode = MODE_IDENT;
        end
      end
    endcase
  end

  // One step of the lexer: keyword release, the byte itself, a fresh token
  // start and the close at the end of the text, in that order.
  always_comb begin
    kid_eff = (keyword_id < 3'd5) ? keyword_id : KW_NOT;
    len_c   = kw_len(kid_eff);
    kwk     = kw_kind(kid_eff);
    kw_cont = (lex_mode == MODE_KEYWORD) && (keyword_matched != 2'd0) &&
              ({1'b0, keyword_matched} < len_c) &&
              (b == kw_char(kid_eff, keyword_matched));
    kw_done = kw_cont && (({1'b0, keyword_matched} + 3'd1) == len_c);
    kw_fail = (lex_mode == MODE_KEYWORD) && !kw_cont;
    // A failed keyword is released and the byte then continues an identifier.
    eff_mode = kw_fail ? MODE_IDENT : lex_mode;

    for (int k = 0; k < NUM_CAND; k++) begin
      cand[k] = '0;
    end
    cv        = '0;
    use_fresh = 1'b0;
    mode1     = lex_mode;
    hp1       = number_has_point;
    km1       = kw_fail ? 2'd0 : keyword_matched;
    kid1      = keyword_id;
    drop1     = drop_rest;
    pend_we   = 1'b0;
    pend_idx  = keyword_matched;
    run_kind  = KIND_IDENT;
    pair_kind = KIND_SMALLER_EQ;

    // Held keyword letters, either as the keyword or as an identifier start.
    for (int i = 0; i < 3; i++) begin
      cv[i]   = (kw_done || kw_fail) && (2'(i) < keyword_matched);
      cand[i] = mk(kw_done ? kwk : KIND_IDENT, keyword_pending[i], 1'b1,
                   (i == 0), 1'b0, 1'b0);
    end

    unique case (eff_mode)
      MODE_IDENT, MODE_SYMBOL: begin
        run_kind = (eff_mode == MODE_IDENT) ? KIND_IDENT : KIND_SYMBOL;
        cv[3]    = 1'b1;
        if (is_alnum(b)) begin
          cand[3] = mk(run_kind, b, 1'b1, 1'b0, 1'b0, 1'b0);
          mode1   = eff_mode;
        end else begin
          cand[3]   = mk(run_kind, b, 1'b0, 1'b0, 1'b1, 1'b0);
          use_fresh = 1'b1;
        end
      end
      MODE_STRING: begin
        cv[3] = 1'b1;
        if (b == CH_QUOTE) begin
          cand[3] = mk(KIND_STRING, b, 1'b0, 1'b0, 1'b1, 1'b0);
          mode1   = MODE_IDLE;
        end else begin
          cand[3] = mk(KIND_STRING, b, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      MODE_NUMBER: begin
        run_kind = number_has_point ? KIND_FLOAT : KIND_INT;
        cv[3]    = 1'b1;
        if (is_digit(b)) begin
          cand[3] = mk(run_kind, b, 1'b1, 1'b0, 1'b0, 1'b0);
        end else if (b == CH_DOT) begin
          if (number_has_point) begin
            // Second decimal point: error result, the rest of the text is dropped.
            cand[3] = mk(KIND_FLOAT, b, 1'b0, 1'b0, 1'b1, 1'b1);
            drop1   = 1'b1;
            mode1   = MODE_IDLE;
          end else begin
            cand[3] = mk(KIND_FLOAT, b, 1'b1, 1'b0, 1'b0, 1'b0);
            hp1     = 1'b1;
          end
        end else begin
          cand[3]   = mk(run_kind, b, 1'b0, 1'b0, 1'b1, 1'b0);
          use_fresh = 1'b1;
        end
      end
      MODE_KEYWORD: begin
        if (kw_done) begin
          cv[3]   = 1'b1;
          cand[3] = mk(kwk, b, 1'b1, 1'b0, 1'b1, 1'b0);
          mode1   = MODE_IDLE;
          km1     = 2'd0;
        end else begin
          pend_we = 1'b1;
          km1     = keyword_matched + 2'd1;
        end
      end
      MODE_GT: begin
        cv[3] = 1'b1;
        if (b == CH_EQUAL) begin
          cv[4]   = 1'b1;
          cand[3] = mk(KIND_GREATER_EQ, CH_GT, 1'b1, 1'b1, 1'b0, 1'b0);
          cand[4] = mk(KIND_GREATER_EQ, b, 1'b1, 1'b0, 1'b1, 1'b0);
          mode1   = MODE_IDLE;
        end else begin
          cand[3]   = mk(KIND_GREATER, CH_GT, 1'b1, 1'b1, 1'b1, 1'b0);
          use_fresh = 1'b1;
        end
      end
      MODE_LT: begin
        cv[3] = 1'b1;
        if ((b == CH_EQUAL) || (b == CH_GT)) begin
          pair_kind = (b == CH_EQUAL) ? KIND_SMALLER_EQ : KIND_INEQUAL;
          cv[4]     = 1'b1;
          cand[3]   = mk(pair_kind, CH_LT, 1'b1, 1'b1, 1'b0, 1'b0);
          cand[4]   = mk(pair_kind, b, 1'b1, 1'b0, 1'b1, 1'b0);
          mode1     = MODE_IDLE;
        end else begin
          cand[3]   = mk(KIND_SMALLER, CH_LT, 1'b1, 1'b1, 1'b1, 1'b0);
          use_fresh = 1'b1;
        end
      end
      MODE_AMP: begin
        cv[3] = 1'b1;
        if (b == CH_AMP) begin
          cv[4]   = 1'b1;
          cand[3] = mk(KIND_SPACE_CONCAT, CH_AMP, 1'b1, 1'b1, 1'b0, 1'b0);
          cand[4] = mk(KIND_SPACE_CONCAT, CH_AMP, 1'b1, 1'b0, 1'b1, 1'b0);
          mode1   = MODE_IDLE;
        end else begin
          cand[3]   = mk(KIND_CONCAT, CH_AMP, 1'b1, 1'b1, 1'b1, 1'b0);
          use_fresh = 1'b1;
        end
      end
      default: use_fresh = 1'b1;
    endcase

    if (use_fresh) begin
      cv[5]   = fresh_v;
      cand[5] = fresh_tok;
      mode1   = fresh_mode;
      if (fresh_mode == MODE_NUMBER) begin
        hp1 = 1'b0;
      end
      if (fresh_kw) begin
        kid1     = fresh_kid;
        km1      = 2'd1;
        pend_we  = 1'b1;
        pend_idx = 2'd0;
      end
    end

    for (int i = 0; i < 3; i++) begin
      pend1[i] = (pend_we && (pend_idx == 2'(i))) ? b : keyword_pending[i];
    end

    // Close of any open token at the end of the text.
    if (last) begin
      unique case (mode1)
        MODE_IDENT: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_IDENT, b, 1'b0, 1'b0, 1'b1, 1'b0);
        end
        MODE_SYMBOL: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_SYMBOL, b, 1'b0, 1'b0, 1'b1, 1'b0);
        end
        MODE_STRING: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_STRING, b, 1'b0, 1'b0, 1'b1, 1'b0);
        end
        MODE_NUMBER: begin
          cv[9]   = 1'b1;
          cand[9] = mk(hp1 ? KIND_FLOAT : KIND_INT, b, 1'b0, 1'b0, 1'b1, 1'b0);
        end
        MODE_KEYWORD: begin
          for (int i = 0; i < 3; i++) begin
            cv[6 + i]   = (2'(i) < km1);
            cand[6 + i] = mk(KIND_IDENT, pend1[i], 1'b1, (i == 0), 1'b0, 1'b0);
          end
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_IDENT, b, 1'b0, 1'b0, 1'b1, 1'b0);
        end
        MODE_GT: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_GREATER, CH_GT, 1'b1, 1'b1, 1'b1, 1'b0);
        end
        MODE_LT: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_SMALLER, CH_LT, 1'b1, 1'b1, 1'b1, 1'b0);
        end
        MODE_AMP: begin
          cv[9]   = 1'b1;
          cand[9] = mk(KIND_CONCAT, CH_AMP, 1'b1, 1'b1, 1'b1, 1'b0);
        end
        default: cv[9] = 1'b0;
      endcase
    end

    // Once the text is being dropped a byte causes nothing.
    if (drop_rest) begin
      cv = '0;
    end

    cnt = '0;
    res = '0;
    for (int k = 0; k < NUM_CAND; k++) begin
      if (cv[k] && (cnt != COUNT_W'(MAX_RESULTS))) begin
        res[cnt[IDX_W-1:0]] = cand[k];
        cnt = cnt + COUNT_W'(1);
      end
    end

    if (last) begin
      lex_mode_next         = MODE_IDLE;
      number_has_point_next = 1'b0;
      keyword_id_next       = KW_NOT;
      keyword_matched_next  = 2'd0;
      drop_rest_next        = 1'b0;
    end else if (drop_rest) begin
      lex_mode_next         = lex_mode;
      number_has_point_next = number_has_point;
      keyword_id_next       = keyword_id;
      keyword_matched_next  = keyword_matched;
      drop_rest_next        = drop_rest;
    end else begin
      lex_mode_next         = mode1;
      number_has_point_next = hp1;
      keyword_id_next       = kid1;
      keyword_matched_next  = km1;
      drop_rest_next        = drop1;
    end
  end

  assign push              = accept && (cnt != '0);
  assign push_packet.count = cnt;
  assign push_packet.toks  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= MODE_IDLE;
      number_has_point <= 1'b0;
      keyword_id       <= KW_NOT;
      keyword_matched  <= 2'd0;
      drop_rest        <= 1'b0;
    end else if (accept) begin
      lex_mode         <= lex_mode_next;
      number_has_point <= number_has_point_next;
      keyword_id       <= keyword_id_next;
      keyword_matched  <= keyword_matched_next;
      drop_rest        <= drop_rest_next;
    end
  end

  // Held keyword letters are only read where they were written.
  always_ff @(posedge clk) begin
    if (accept && !drop_rest && pend_we) begin
      keyword_pending[pend_idx] <= b;
    end
  end

endmodule

@@ rtl/plt_queue.sv @@
// ----------------------------------------------------------------------------
// plt_queue
// Small first-in first-out queue of result packets between the lexer front
// and the result sequencer.
// ----------------------------------------------------------------------------
module plt_queue #(
  parameter int DEPTH = plt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  plt_pkg::packet_t push_packet,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output plt_pkg::packet_t head
);
  import plt_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  packet_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign full       = (fill == CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_packet;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/plt_back.sv @@
// ----------------------------------------------------------------------------
// plt_back
// Result sequencer. Walks through the packet at the head of the queue and
// hands out its results one per unstalled cycle, marking the last one of each run.
// ----------------------------------------------------------------------------
module plt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  plt_pkg::packet_t     head,
  output logic                 pop,
  output logic                 token_valid,
  input  logic                 token_stall,
  output plt_pkg::token_item_t token_item
);
  import plt_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             at_last;
  logic             taken;
  tok_t             cur;

  assign cur     = head.toks[idx];
  assign at_last = ((COUNT_W'(idx) + COUNT_W'(1)) == head.count);
  assign taken   = token_valid && !token_stall;
  assign pop     = taken && at_last;

  assign token_valid            = head_valid;
  assign token_item.token_kind  = cur.token_kind;
  assign token_item.value_byte  = cur.value_byte;
  assign token_item.has_byte    = cur.has_byte;
  assign token_item.token_begin = cur.token_begin;
  assign token_item.token_end   = cur.token_end;
  assign token_item.failed      = cur.failed;
  assign token_item.last_of_run = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (taken) begin
      idx <= at_last ? '0 : idx + IDX_W'(1);
    end
  end

endmodule

@@ rtl/property_list_text_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// property_list_text_lexer_unit
// Streaming tokenizer for property-list text: one text byte in, token pieces
// out, with begin and end marks on each token.
//
//   channel  direction  handshake                 payload
//   text     in         text_valid / text_stall   plt_pkg::text_item_t
//   token    out        token_valid / token_stall plt_pkg::token_item_t
//
// A text byte is taken every cycle while the packet queue has room; its
// results are registered in the queue and handed out one per cycle while
// the output is not stalled; up to QUEUE_DEPTH bytes worth of results
// wait in the queue meanwhile.
// A byte that causes no result only updates the lexer state.
// Synchronous reset returns the lexer to idle and empties the queue.
// ----------------------------------------------------------------------------
module property_list_text_lexer_unit #(
  parameter int QUEUE_DEPTH = plt_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  plt_pkg::text_item_t  text_item,
  output logic                 token_valid,
  input  logic                 token_stall,
  output plt_pkg::token_item_t token_item
);
  import plt_pkg::*;

  logic    push;
  packet_t push_packet;
  logic    queue_full;
  logic    pop;
  logic    head_valid;
  packet_t head;

  plt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .push        (push),
    .push_packet (push_packet),
    .queue_full  (queue_full)
  );

  plt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_packet (push_packet),
    .full        (queue_full),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  plt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
  );

endmodule

@@ rtl/plt_checker.sv @@
// ----------------------------------------------------------------------------
// plt_checker
// Port-level checks of the lexer: output handshake and the shape of the
// results it hands out.
// ----------------------------------------------------------------------------
module plt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 text_valid,
  input logic                 text_stall,
  input plt_pkg::text_item_t  text_item,
  input logic                 token_valid,
  input logic                 token_stall,
  input plt_pkg::token_item_t token_item
);
  import plt_pkg::*;

  logic text_taken;
  assign text_taken = text_valid && !text_stall && text_item.last_char;

  // A stalled result is neither withdrawn nor changed.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid)
    else $error("token result withdrawn while stalled");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> $stable(token_item))
    else $error("token result changed while stalled");

  // The error result closes a decimal, carries no byte and ends its run.
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_item.failed |->
      token_item.token_end && token_item.last_of_run && !token_item.has_byte &&
      (token_item.token_kind == KIND_FLOAT))
    else $error("malformed error result");

  // Without a value byte the byte field is zero.
  a_empty_byte: assert property (@(posedge clk) disable iff (rst || text_taken)
    token_valid && !token_item.has_byte |-> (token_item.value_byte == 8'h00))
    else $error("value byte set on a result without a byte");

  // A token opened and closed by one result is a one-character token.
  a_single_byte: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_item.token_begin && token_item.token_end |->
      token_item.has_byte)
    else $error("single-result token without a byte");

endmodule

bind property_list_text_lexer_unit plt_checker u_plt_checker (.*);

@@ sim/property_list_text_lexer_checker.sv @@
// ----------------------------------------------------------------------------
// property_list_text_lexer_checker
// Watches the text and token channels of the lexer. Every accepted text byte
// runs through a behavioral copy of the tokenizer, and the token pieces it
// should cause are queued. Every accepted token item is compared field by
// field with the oldest queued piece. The mismatch count and the number of
// pieces still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module property_list_text_lexer_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  input  logic                 text_stall,
  input  plt_pkg::text_item_t  text_item,
  input  logic                 token_valid,
  input  logic                 token_stall,
  input  plt_pkg::token_item_t token_item,
  output int unsigned          error_count,
  output int unsigned          pending
);
  import plt_pkg::*;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  typedef enum logic [3:0] {
    LEX_IDLE, LEX_IDENT, LEX_NUMBER, LEX_SYMBOL, LEX_STRING, LEX_KEYWORD,
    LEX_GT, LEX_LT, LEX_AMP
  } lex_mode_t;

  typedef enum logic [2:0] {KW_NOT, KW_AND, KW_OR, KW_MOD, KW_VOID} keyword_t;

  lex_mode_t   mode;
  logic        point_seen;
  logic [7:0]  held [3];
  keyword_t    kw_sel;
  logic [1:0]  kw_count;
  logic        dropping;
  token_item_t step_toks [$];
  token_item_t expected_tokens [$];
  int unsigned errors = 0;

  initial begin
    error_count = 0;
    pending     = 0;
  end

  // Keyword text, left aligned in a 32-bit word.
  function automatic logic [31:0] kw_text(keyword_t k);
    case (k)
      KW_NOT:  return {"not", 8'h00};
      KW_AND:  return {"and", 8'h00};
      KW_OR:   return {"or", 16'h0000};
      KW_MOD:  return {"mod", 8'h00};
      default: return "void";
    endcase
  endfunction

  function automatic int unsigned kw_len(keyword_t k);
    case (k)
      KW_OR:   return 2;
      KW_VOID: return 4;
      default: return 3;
    endcase
  endfunction

  function automatic logic [4:0] kw_kind(keyword_t k);
    case (k)
      KW_NOT:  return KIND_NOT;
      KW_AND:  return KIND_AND;
      KW_OR:   return KIND_OR;
      KW_MOD:  return KIND_MOD;
      default: return KIND_VOID;
    endcase
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return is_digit(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic void emit_piece(logic [4:0] kind, logic [7:0] b, logic has,
                                     logic first, logic fin, logic fail);
    token_item_t t;
    if (step_toks.size() >= MAX_RESULTS) return;
    t.token_kind  = kind;
    t.value_byte  = has ? b : 8'h00;
    t.has_byte    = has;
    t.token_begin = first;
    t.token_end   = fin;
    t.failed      = fail;
    t.last_of_run = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic void start_keyword(keyword_t k, logic [7:0] b);
    kw_sel   = k;
    held[0]  = b;
    kw_count = 2'd1;
    mode     = LEX_KEYWORD;
  endfunction

  function automatic void open_token(logic [7:0] b);
    mode = LEX_IDLE;
    case (b)
      " ", CH_CR, CH_LF, CH_TAB: ;
      "[": emit_piece(KIND_LBRACK, b, 1, 1, 1, 0);
      "]": emit_piece(KIND_RBRACK, b, 1, 1, 1, 0);
      "(": emit_piece(KIND_LPAREN, b, 1, 1, 1, 0);
      ")": emit_piece(KIND_RPAREN, b, 1, 1, 1, 0);
      ":": emit_piece(KIND_COLON, b, 1, 1, 1, 0);
      ",": emit_piece(KIND_COMMA, b, 1, 1, 1, 0);
      "+": emit_piece(KIND_PLUS, b, 1, 1, 1, 0);
      "-": emit_piece(KIND_MINUS, b, 1, 1, 1, 0);
      "*": emit_piece(KIND_TIMES, b, 1, 1, 1, 0);
      "/": emit_piece(KIND_DIVIDE, b, 1, 1, 1, 0);
      "=": emit_piece(KIND_EQUAL, b, 1, 1, 1, 0);
      ">": mode = LEX_GT;
      "<": mode = LEX_LT;
      "&": mode = LEX_AMP;
      "#": begin
        emit_piece(KIND_SYMBOL, 8'h00, 0, 1, 0, 0);
        mode = LEX_SYMBOL;
      end
      "\"": begin
        emit_piece(KIND_STRING, 8'h00, 0, 1, 0, 0);
        mode = LEX_STRING;
      end
      "n": start_keyword(KW_NOT, b);
      "a": start_keyword(KW_AND, b);
      "o": start_keyword(KW_OR, b);
      "m": start_keyword(KW_MOD, b);
      "v": start_keyword(KW_VOID, b);
      default: begin
        if (is_digit(b)) begin
          emit_piece(KIND_INT, b, 1, 1, 0, 0);
          point_seen = 1'b0;
          mode       = LEX_NUMBER;
        end else begin
          emit_piece(KIND_IDENT, b, 1, 1, 0, 0);
          mode = LEX_IDENT;
        end
      end
    endcase
  endfunction

  // Letters held while a keyword was being matched become an identifier.
  function automatic void release_held();
    for (int i = 0; i < kw_count; i++)
      emit_piece(KIND_IDENT, held[i], 1, i == 0, 0, 0);
    kw_count = 2'd0;
    mode     = LEX_IDENT;
  endfunction

  function automatic void continue_word(logic [7:0] b);
    logic [4:0] kind;
    kind = (mode == LEX_IDENT) ? KIND_IDENT : KIND_SYMBOL;
    if (is_alnum(b)) begin
      emit_piece(kind, b, 1, 0, 0, 0);
    end else begin
      emit_piece(kind, 8'h00, 0, 0, 1, 0);
      open_token(b);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    logic [31:0] word;
    logic [4:0]  kind;
    int unsigned len;
    case (mode)
      LEX_IDENT, LEX_SYMBOL: continue_word(b);
      LEX_STRING: begin
        if (b == "\"") begin
          emit_piece(KIND_STRING, 8'h00, 0, 0, 1, 0);
          mode = LEX_IDLE;
        end else begin
          emit_piece(KIND_STRING, b, 1, 0, 0, 0);
        end
      end
      LEX_NUMBER: begin
        if (is_digit(b)) begin
          emit_piece(point_seen ? KIND_FLOAT : KIND_INT, b, 1, 0, 0, 0);
        end else if (b == ".") begin
          if (point_seen) begin
            // A second point is an error; the rest of the text is dropped.
            emit_piece(KIND_FLOAT, 8'h00, 0, 0, 1, 1);
            dropping = 1'b1;
            mode     = LEX_IDLE;
          end else begin
            point_seen = 1'b1;
            emit_piece(KIND_FLOAT, b, 1, 0, 0, 0);
          end
        end else begin
          emit_piece(point_seen ? KIND_FLOAT : KIND_INT, 8'h00, 0, 0, 1, 0);
          open_token(b);
        end
      end
      LEX_KEYWORD: begin
        word = kw_text(kw_sel);
        len  = kw_len(kw_sel);
        kind = kw_kind(kw_sel);
        if (kw_count >= 1 && kw_count < len && b == word[31 - 8 * int'(kw_count) -: 8]) begin
          if (kw_count + 1 == len) begin
            for (int i = 0; i < kw_count; i++)
              emit_piece(kind, held[i], 1, i == 0, 0, 0);
            emit_piece(kind, b, 1, 0, 1, 0);
            kw_count = 2'd0;
            mode     = LEX_IDLE;
          end else begin
            held[kw_count] = b;
            kw_count       = kw_count + 2'd1;
          end
        end else begin
          release_held();
          continue_word(b);
        end
      end
      LEX_GT: begin
        if (b == "=") begin
          emit_piece(KIND_GREATER_EQ, ">", 1, 1, 0, 0);
          emit_piece(KIND_GREATER_EQ, "=", 1, 0, 1, 0);
          mode = LEX_IDLE;
        end else begin
          emit_piece(KIND_GREATER, ">", 1, 1, 1, 0);
          open_token(b);
        end
      end
      LEX_LT: begin
        if (b == "=" || b == ">") begin
          kind = (b == "=") ? KIND_SMALLER_EQ : KIND_INEQUAL;
          emit_piece(kind, "<", 1, 1, 0, 0);
          emit_piece(kind, b, 1, 0, 1, 0);
          mode = LEX_IDLE;
        end else begin
          emit_piece(KIND_SMALLER, "<", 1, 1, 1, 0);
          open_token(b);
        end
      end
      LEX_AMP: begin
        if (b == "&") begin
          emit_piece(KIND_SPACE_CONCAT, "&", 1, 1, 0, 0);
          emit_piece(KIND_SPACE_CONCAT, "&", 1, 0, 1, 0);
          mode = LEX_IDLE;
        end else begin
          emit_piece(KIND_CONCAT, "&", 1, 1, 1, 0);
          open_token(b);
        end
      end
      default: open_token(b);
    endcase
  endfunction

  // End of text: whatever token is open gets closed.
  function automatic void close_text();
    case (mode)
      LEX_IDENT:  emit_piece(KIND_IDENT, 8'h00, 0, 0, 1, 0);
      LEX_SYMBOL: emit_piece(KIND_SYMBOL, 8'h00, 0, 0, 1, 0);
      LEX_STRING: emit_piece(KIND_STRING, 8'h00, 0, 0, 1, 0);
      LEX_NUMBER: emit_piece(point_seen ? KIND_FLOAT : KIND_INT, 8'h00, 0, 0, 1, 0);
      LEX_KEYWORD: begin
        release_held();
        emit_piece(KIND_IDENT, 8'h00, 0, 0, 1, 0);
      end
      LEX_GT:  emit_piece(KIND_GREATER, ">", 1, 1, 1, 0);
      LEX_LT:  emit_piece(KIND_SMALLER, "<", 1, 1, 1, 0);
      LEX_AMP: emit_piece(KIND_CONCAT, "&", 1, 1, 1, 0);
      default: ;
    endcase
  endfunction

  function automatic void reset_lexer();
    mode       = LEX_IDLE;
    point_seen = 1'b0;
    held[0]    = 8'h00;
    held[1]    = 8'h00;
    held[2]    = 8'h00;
    kw_sel     = KW_NOT;
    kw_count   = 2'd0;
    dropping   = 1'b0;
  endfunction

  function automatic void predict_tokens(text_item_t it);
    token_item_t t;
    step_toks.delete();
    if (!dropping) lex_byte(it.char_byte);
    if (it.last_char) begin
      if (!dropping) close_text();
      reset_lexer();
    end
    foreach (step_toks[i]) begin
      t             = step_toks[i];
      t.last_of_run = (i == step_toks.size() - 1);
      expected_tokens = {expected_tokens, t};
    end
  endfunction

  function automatic string show(token_item_t t);
    return $sformatf("kind=%0d byte=%02h has=%b begin=%b end=%b failed=%b last=%b",
                     t.token_kind, t.value_byte, t.has_byte, t.token_begin,
                     t.token_end, t.failed, t.last_of_run);
  endfunction

  function automatic void check_token(token_item_t got);
    token_item_t want;
    if (expected_tokens.size() == 0) begin
      $display("%0t: unexpected token item, expected none, actual %s", $time, show(got));
      errors++;
    end else begin
      want = expected_tokens.pop_front();
      if (got !== want) begin
        $display("%0t: token mismatch, expected %s, actual %s", $time, show(want), show(got));
        errors++;
      end
    end
  endfunction

  // A token item accepted at an edge can never come from the text byte
  // accepted at that same edge, so the compare goes first.
  always @(posedge clk) begin
    if (rst) begin
      reset_lexer();
      expected_tokens.delete();
    end else begin
      if (token_valid && !token_stall) check_token(token_item);
      if (text_valid && !text_stall) predict_tokens(text_item);
    end
    pending     <= expected_tokens.size();
    error_count <= errors;
  end

endmodule

@@ sim/tb_property_list_text_lexer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_property_list_text_lexer_unit
// Feeds the lexer short directed texts for operators, punctuation, lone '<',
// a second decimal point and an unterminated string, then random texts built
// from well-formed tokens with random content mixed with noise bytes. Both
// sides stall at random in two settings, then not at all. The checker compares.
// ----------------------------------------------------------------------------
module tb_property_list_text_lexer_unit;
  import plt_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 32;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_CR  = 8'h0d;

  typedef enum int {
    PIECE_PUNCT, PIECE_OPERATOR, PIECE_KEYWORD, PIECE_IDENT, PIECE_NUMBER,
    PIECE_STRING, PIECE_SYMBOL, PIECE_NOISE
  } piece_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        text_valid  = 1'b0;
  text_item_t  text_item   = '0;
  logic        token_stall = 1'b0;
  logic        text_stall;
  logic        token_valid;
  token_item_t token_item;
  int unsigned error_count;
  int unsigned pending;

  int unsigned gap_pct     = 13;
  int unsigned stall_pct   = 64;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  logic [7:0]  text_buf [$];

  string singles     = "[]():,+-*/=<>&";
  string pairs [4]   = '{"<>", "<=", ">=", "&&"};
  string keywords [5] = '{"not", "and", "or", "mod", "void"};

  property_list_text_lexer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item)
  );

  property_list_text_lexer_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_item  (token_item),
    .error_count (error_count),
    .pending     (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    token_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] b, input logic fin);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_item  <= '{char_byte: b, last_char: fin};
    do @(posedge clk); while (text_stall);
    sent_count++;
  endtask

  // Sends the buffered text; the final byte carries the end-of-text flag.
  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  function automatic void append_byte(logic [7:0] c);
    text_buf = {text_buf, c};
  endfunction

  function automatic void queue_string(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return CH_CR;
      2:       return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  // Appends one token-shaped piece of text; returns 1 when the piece ends
  // the text because everything after it would be dropped anyway.
  function automatic logic add_piece();
    piece_t      piece;
    int unsigned k;
    int unsigned n;
    logic [7:0]  b;
    logic        ends_text;
    piece     = piece_t'($urandom_range(0, 7));
    ends_text = 1'b0;
    case (piece)
      PIECE_PUNCT: append_byte(singles[$urandom_range(0, singles.len() - 1)]);
      PIECE_OPERATOR: begin
        k = $urandom_range(0, 3);
        append_byte(pairs[k][0]);
        append_byte(pairs[k][1]);
      end
      PIECE_KEYWORD: begin
        // Mostly whole keywords, sometimes a prefix that turns into a name.
        k = $urandom_range(0, 4);
        n = $urandom_range(0, 2) != 0 ? keywords[k].len() : $urandom_range(1, keywords[k].len());
        for (int i = 0; i < n; i++) append_byte(keywords[k][i]);
        if ($urandom_range(0, 3) == 0) append_byte(rand_alnum());
      end
      PIECE_IDENT: begin
        case ($urandom_range(0, 2))
          0:       append_byte(8'("A" + $urandom_range(0, 25)));
          1:       append_byte(8'(8'h80 + $urandom_range(0, 127)));
          default: append_byte(rand_alnum());
        endcase
        repeat ($urandom_range(0, 3)) append_byte(rand_alnum());
      end
      PIECE_NUMBER: begin
        repeat ($urandom_range(1, 3)) append_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1) != 0) begin
          append_byte(".");
          repeat ($urandom_range(0, 2)) append_byte(8'("0" + $urandom_range(0, 9)));
          if ($urandom_range(0, 7) == 0) begin
            append_byte(".");
            append_byte(8'("0" + $urandom_range(0, 9)));
            ends_text = 1'b1;
          end
        end
      end
      PIECE_STRING: begin
        append_byte("\"");
        repeat ($urandom_range(0, 4)) begin
          do b = 8'($urandom_range(0, 255)); while (b == "\"");
          append_byte(b);
        end
        if ($urandom_range(0, 5) != 0) append_byte("\"");
      end
      PIECE_SYMBOL: begin
        append_byte("#");
        repeat ($urandom_range(0, 3)) append_byte(rand_alnum());
      end
      default: append_byte(8'($urandom_range(0, 255)));
    endcase
    return ends_text;
  endfunction

  initial begin
    int unsigned random_from;
    int unsigned progress;
    int unsigned pieces;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every punctuation mark and operator, all pending-character cases but a lone '>'.
    queue_string("[]():,+-*/=<><=>=&&&<x");
    send_text();
    // A second decimal point; the byte after it is dropped.
    queue_string("1.2.");
    append_byte(8'hff);
    send_text();
    // A string left open at the end of the text.
    queue_string("\"");
    append_byte(8'h00);
    send_text();
    // A lone '<' at the end of the text.
    queue_string("<");
    send_text();

    // Let everything drain before the random part starts.
    text_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    random_from = sent_count;
    while (sent_count < random_from + RANDOM_ITEMS) begin
      progress = sent_count - random_from;
      if (progress >= 2 * RANDOM_ITEMS / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (progress >= RANDOM_ITEMS / 3) begin
        gap_pct   = 64;
        stall_pct = 13;
      end
      pieces = $urandom_range(1, 5);
      for (int p = 0; p < pieces; p++) begin
        if (add_piece()) break;
        if ($urandom_range(0, 1) != 0) append_byte(rand_space());
      end
      send_text();
    end

    text_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/plt_pkg.sv
rtl/plt_front.sv
rtl/plt_queue.sv
rtl/plt_back.sv
rtl/property_list_text_lexer_unit.sv
rtl/plt_checker.sv
sim/property_list_text_lexer_checker.sv
sim/tb_property_list_text_lexer_unit.sv
